>>> hdl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package b64d_pkg;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Index of the last result of a job
    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;

    // One job: the one to three result beats that a single input beat causes
    typedef struct packed {
        logic [23:0] bytes;     // first byte in [7:0], then [15:8], [23:16]
        logic [1:0]  last_idx;  // index of the final result of the job
        logic        byte_ok;   // results carry decoded bytes
        logic        fin_end;   // final result ends the text
        logic        fin_ok;    // final result reports success
    } job_t;

    // Lookup result: ok flag and 6-bit value
    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    // Map an ASCII character to its 6-bit base64 value
    function automatic sextet_t sextet_lookup(input logic [7:0] c);
        sextet_t r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2F) begin
            r.value = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hdl/base64_strict_stream_decoder.sv
// Top level of the strict base64 stream decoder: front, job queue and back.
// Uses b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//   channel | direction | tdata            | tuser                      | tlast
//   s_      | in        | [7:0] symbol     | [0] symbol_present         | end_of_text
//   m_      | out       | [7:0] data_byte  | [0] byte_valid [1] success | end_of_output
//
// One character beat is accepted per cycle while the job queue has room.
// A completed group yields one to three result beats, one per cycle from the
// output register while m_tready is high, each job passing the queue and cur_reg.
// Reset (aresetn low, synchronous) clears the group state, queue and m_tvalid.
// A stalled m_ side fills the QUEUE_DEPTH-entry job queue, then s_tready drops.
module base64_strict_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tuser,   // [0] symbol_present
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] success
    output logic       m_tlast    // end_of_output
);

    logic q_full;
    logic q_push;
    job_t push_job;
    logic q_pop;
    logic q_valid;
    job_t q_job;

    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/b64d_front.sv
// Input side of the base64 decoder: accepts character beats, tracks the group
// and its checks, and pushes one job per beat that yields results. Uses b64d_pkg.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tuser,   // [0] symbol_present
    input  logic       s_tlast,   // end_of_text
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] held_reg, held_next;
    logic        pad_reg, pad_next;
    logic        disc_reg, disc_next;

    logic        accept;
    sextet_t     sx;
    logic        is_pad;
    logic        fail;
    logic [7:0]  b0, b1, b2;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign sx       = sextet_lookup(s_tdata);
    assign is_pad   = (s_tdata == PAD_CHAR);
    assign b0       = held_reg[17:10];
    assign b1       = held_reg[9:2];
    assign b2       = {held_reg[1:0], sx.value};

    // Classify the beat and decide the next group state and the job
    always_comb begin
        pos_next  = pos_reg;
        held_next = held_reg;
        pad_next  = pad_reg;
        disc_next = disc_reg;
        fail      = 1'b0;
        q_push    = 1'b0;
        q_job     = '0;
        if (accept) begin
            if (disc_reg) begin
                // drop until end of text
                if (s_tlast) begin
                    disc_next = 1'b0;
                end
            end else if (!s_tuser) begin
                if (s_tlast) begin
                    if (pos_reg != 2'd0) begin
                        fail = 1'b1;
                    end else begin
                        // empty text
                        q_push         = 1'b1;
                        q_job.last_idx = LAST_IDX_ONE;
                        q_job.fin_end  = 1'b1;
                        q_job.fin_ok   = 1'b1;
                    end
                end
            end else if (pos_reg < 2'd2) begin
                if (!sx.ok || s_tlast) begin
                    fail = 1'b1;
                end else begin
                    held_next = {held_reg[11:0], sx.value};
                    pos_next  = pos_reg + 2'd1;
                end
            end else if (pos_reg == 2'd2) begin
                if (s_tlast) begin
                    fail = 1'b1;
                end else if (is_pad) begin
                    if (held_reg[3:0] != 4'd0) begin
                        fail = 1'b1;
                    end else begin
                        pad_next  = 1'b1;
                        held_next = {held_reg[11:0], 6'd0};
                        pos_next  = 2'd3;
                    end
                end else if (!sx.ok) begin
                    fail = 1'b1;
                end else begin
                    held_next = {held_reg[11:0], sx.value};
                    pos_next  = 2'd3;
                end
            end else begin
                // fourth character of the group
                if (pad_reg) begin
                    if (!is_pad || !s_tlast) begin
                        fail = 1'b1;
                    end else begin
                        q_push         = 1'b1;
                        q_job.bytes    = {16'd0, b0};
                        q_job.last_idx = LAST_IDX_ONE;
                        q_job.byte_ok  = 1'b1;
                        q_job.fin_end  = 1'b1;
                        q_job.fin_ok   = 1'b1;
                    end
                end else if (is_pad) begin
                    if (!s_tlast || held_reg[1:0] != 2'd0) begin
                        fail = 1'b1;
                    end else begin
                        q_push         = 1'b1;
                        q_job.bytes    = {8'd0, b1, b0};
                        q_job.last_idx = LAST_IDX_TWO;
                        q_job.byte_ok  = 1'b1;
                        q_job.fin_end  = 1'b1;
                        q_job.fin_ok   = 1'b1;
                    end
                end else if (!sx.ok) begin
                    fail = 1'b1;
                end else begin
                    q_push         = 1'b1;
                    q_job.bytes    = {b2, b1, b0};
                    q_job.last_idx = LAST_IDX_THREE;
                    q_job.byte_ok  = 1'b1;
                    q_job.fin_end  = s_tlast;
                    q_job.fin_ok   = s_tlast;
                end
                pos_next  = 2'd0;
                held_next = '0;
                pad_next  = 1'b0;
            end

            // End of text or an error clears the group
            if (!disc_reg && (fail || (s_tuser && s_tlast) || (!s_tuser && s_tlast))) begin
                pos_next  = 2'd0;
                held_next = '0;
                pad_next  = 1'b0;
            end
            if (fail) begin
                disc_next      = !s_tlast;
                q_push         = 1'b1;
                q_job          = '0;
                q_job.last_idx = LAST_IDX_ONE;
                q_job.fin_end  = 1'b1;
                q_job.fin_ok   = 1'b0;
            end
        end
    end

    // Hold the group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            held_reg <= '0;
            pad_reg  <= 1'b0;
            disc_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
            pad_reg  <= pad_next;
            disc_reg <= disc_next;
        end
    end

endmodule

>>> hdl/b64d_queue.sv
// Short job queue between the decoder front and back, a ring of DEPTH entries.
// Uses b64d_pkg for the job type.
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output job_t q_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign q_job   = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the job payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || do_pop)
        else $error("job pushed into a full queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance on push");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

>>> hdl/b64d_back.sv
// Output side of the base64 decoder: takes jobs from the queue and issues their
// result beats through a registered master port. Uses b64d_pkg.
module b64d_back
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] success
    output logic       m_tlast    // end_of_output
);

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic       m_tlast_reg;

    logic       out_free;
    logic       emit;
    logic       fin;
    logic       done;
    logic [7:0] sel_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = out_free && cur_valid_reg;
    assign fin      = (idx_reg == cur_reg.last_idx);
    assign done     = emit && fin;
    assign pop      = q_valid && (!cur_valid_reg || done);

    // Select the byte of the current result
    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.bytes[7:0];
            2'd1:    sel_byte = cur_reg.bytes[15:8];
            default: sel_byte = cur_reg.bytes[23:16];
        endcase
    end

    // Advance through the job, load the next one as the last beat leaves
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = q_job;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end else if (done) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (out_free) begin
                m_tvalid_reg <= cur_valid_reg;
            end
        end
    end

    // Load the current job and the output register payload
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            m_tdata_reg <= sel_byte;
            m_tuser_reg <= {fin && cur_reg.fin_ok, cur_reg.byte_ok};
            m_tlast_reg <= fin && cur_reg.fin_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_bare_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast && m_tdata == 8'd0)
        else $error("result without a byte is not a final zero beat");
    a_success_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("success flagged on a non-final beat");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> idx_reg <= cur_reg.last_idx)
        else $error("result index past the end of the job");
`endif

endmodule
